[hw/rtl/mrse_pkg.sv]
// Shared constants and the CRC-16 byte update for the Modbus RTU slave engine.
// No dependencies; used by the engine core and its checker.
`timescale 1ns / 1ps

package mrse_pkg;

   // Function codes that the slave serves.
   localparam logic [7:0] FC_READ_COILS  = 8'h01;
   localparam logic [7:0] FC_READ_INPUTS = 8'h02;
   localparam logic [7:0] FC_READ_REGS   = 8'h03;
   localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
   localparam logic [7:0] FC_WRITE_REG   = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS  = 8'h10;

   // Exception codes.
   localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
   localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
   localparam logic [7:0] EXC_DEVICE_FAILURE   = 8'h04;

   localparam logic [7:0]  EXC_FLAG   = 8'h80;
   localparam logic [7:0]  COIL_ON    = 8'hFF;
   localparam logic [15:0] ADDR_LIMIT = 16'd1000;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [15:0] HOLD_RESET = 16'hFFFF;

   // One byte of CRC-16/MODBUS, reflected, eight shift steps.
   function automatic logic [15:0] crc_update(input logic [15:0] crc_cur,
                                              input logic [7:0] data);
      logic [15:0] c;
      c = crc_cur ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[hw/rtl/mrse_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the frame bytes and the holding registers.
`timescale 1ns / 1ps

module mrse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/modbus_rtu_slave_engine_core.sv]
// Modbus RTU slave engine top level: frame collection, decode, register update, response.
// Depends on mrse_pkg and mrse_ram.
`timescale 1ns / 1ps
//
//   Channel   Direction  Handshake            Moves
//   req_      in         req_valid/req_ready  one received byte, end mark, input levels
//   rsp_      out        rsp_valid/rsp_ready  one response byte, last mark, coils, count
//
// A received byte is taken whenever the engine is idle.
// After the closing byte: a decode state, then a read and an apply state per data byte for
// a multiple-coil write and a high-byte, low-byte and write state per register for a
// multiple-register write, both paced by the single read port of the frame memory.
// Each response byte then passes holding memory read, byte build and output register,
// plus any stall on rsp_ready; no request is taken meanwhile.
// Synchronous reset clears control, coils, counter and holding-register valid bits.

module modbus_rtu_slave_engine_core #(
   parameter int COIL_COUNT  = 32,
   parameter int INPUT_COUNT = 8,
   parameter int REG_COUNT   = 16,
   parameter int FRAME_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   input  logic [7:0]  req_discrete_inputs,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [31:0] rsp_coil_levels,
   output logic [15:0] rsp_exception_total
);

   localparam int FA = $clog2(FRAME_BYTES);
   localparam int LW = $clog2(FRAME_BYTES + 2);
   localparam int RA = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int KW = $clog2(2 * REG_COUNT + 16);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_WC_READ, S_WC_APPLY, S_WR_HI, S_WR_LO, S_WR_WRITE,
      S_E_ADDR, S_E_BYTE, S_E_WAIT
   } state_type;

   typedef enum logic [1:0] {MODE_EXC, MODE_ECHO, MODE_BITS, MODE_REGS} mode_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [LW-1:0]        len_ff, len_in, n_ff, n_in, n_next;
   logic [7:0]           fb_ff [6];
   logic [7:0]           fb_in [6];
   logic [7:0]           last1_ff, last1_in, last2_ff, last2_in;
   logic [15:0]          crc_ff, crc_in;
   logic [7:0]           din_ff, din_in;
   logic [COIL_COUNT-1:0] coil_ff, coil_in;
   logic [15:0]          exc_cnt_ff, exc_cnt_in;
   logic [REG_COUNT-1:0] hold_valid_ff, hold_valid_in;
   logic [7:0]           code_ff, code_in;
   logic [KW-1:0]        idx_ff, idx_in;
   logic [7:0]           hi_ff, hi_in;
   logic [15:0]          tx_crc_ff, tx_crc_in;
   logic                 rd_zero_ff, rd_zero_in;
   logic                 hvq_ff, hvq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic          fw_en;
   logic [7:0]    frd_data;
   logic [FA-1:0] frd_addr;
   logic          hw_en;
   logic [RA-1:0] hw_addr, hrd_addr;
   logic [15:0]   hw_data, hrd_data;

   // Decode and datapath helpers.
   logic [15:0]   start_f, cnt_f;
   logic [16:0]   sum17;
   logic          fc_ok, range_bad, dec_exc, coil_on;
   logic [7:0]    dec_code;
   logic [8:0]    pos_w;
   logic [7:0]    fbyte;
   logic [2:0]    j_sel;
   logic [7:0]    bitoff, rem, bmask, nbytes8, bitbyte, tx_byte_w;
   logic [63:0]   src64, m64, d64;
   logic [KW-1:0] tmp_idx, body, total;
   logic [15:0]   hword;

   mrse_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock  (clock),
      .wr_en  (fw_en),
      .wr_addr(len_ff[FA-1:0]),
      .wr_data(req_rx_byte),
      .rd_addr(frd_addr),
      .rd_data(frd_data)
   );

   mrse_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_hold_ram (
      .clock  (clock),
      .wr_en  (hw_en),
      .wr_addr(hw_addr),
      .wr_data(hw_data),
      .rd_addr(hrd_addr),
      .rd_data(hrd_data)
   );

   assign start_f = {fb_ff[2], fb_ff[3]};
   assign cnt_f   = {fb_ff[4], fb_ff[5]};
   assign sum17   = {1'b0, start_f} + {1'b0, cnt_f};
   assign coil_on = (fb_ff[4] == mrse_pkg::COIL_ON) || (fb_ff[5] == mrse_pkg::COIL_ON);
   assign n_next  = (len_ff < LW'(FRAME_BYTES)) ? LW'(len_ff + 1'b1) : LW'(FRAME_BYTES + 1);

   // Function code and range checks for the closed frame.
   always_comb begin
      fc_ok     = 1'b1;
      range_bad = 1'b0;
      unique case (fb_ff[1])
         mrse_pkg::FC_READ_COILS, mrse_pkg::FC_WRITE_COILS:
            range_bad = sum17 > 17'(COIL_COUNT);
         mrse_pkg::FC_READ_INPUTS:
            range_bad = sum17 > 17'(INPUT_COUNT);
         mrse_pkg::FC_READ_REGS, mrse_pkg::FC_WRITE_REGS:
            range_bad = sum17 > 17'(REG_COUNT);
         mrse_pkg::FC_WRITE_COIL:
            range_bad = start_f >= 16'(COIL_COUNT);
         mrse_pkg::FC_WRITE_REG:
            range_bad = start_f >= 16'(REG_COUNT);
         default:
            fc_ok = 1'b0;
      endcase
   end

   // Exceptions in priority order: function, start address, CRC, range.
   always_comb begin
      dec_exc  = 1'b1;
      dec_code = mrse_pkg::EXC_ILLEGAL_ADDRESS;
      priority if (!fc_ok) begin
         dec_code = mrse_pkg::EXC_ILLEGAL_FUNCTION;
      end else if (start_f >= mrse_pkg::ADDR_LIMIT) begin
         dec_code = mrse_pkg::EXC_ILLEGAL_ADDRESS;
      end else if (last2_ff != crc_ff[7:0] || last1_ff != crc_ff[15:8]) begin
         dec_code = mrse_pkg::EXC_DEVICE_FAILURE;
      end else if (range_bad) begin
         dec_code = mrse_pkg::EXC_ILLEGAL_ADDRESS;
      end else begin
         dec_exc = 1'b0;
      end
   end

   // Frame positions for the data-field loops; bytes past the frame read as zero.
   assign pos_w = 9'd7 + ((state_ff == S_WC_READ) ? 9'(idx_ff)
                                                  : (9'(idx_ff) << 1) + 9'(state_ff == S_WR_LO));
   assign frd_addr = pos_w[FA-1:0];
   assign fbyte    = rd_zero_ff ? 8'h00 : frd_data;

   // Bit packing shared by the coil write loop and the bit read response.
   assign tmp_idx = idx_ff - KW'(3);
   assign j_sel   = (state_ff == S_WC_APPLY) ? idx_ff[2:0] : tmp_idx[2:0];
   assign bitoff  = 8'(start_f[6:0]) + {2'b00, j_sel, 3'b000};
   assign rem     = 8'(cnt_f[6:0]) - {2'b00, j_sel, 3'b000};
   assign bmask   = ~(8'hFF << rem);
   assign nbytes8 = (8'(cnt_f[6:0]) + 8'd7) >> 3;
   assign src64   = (fb_ff[1] == mrse_pkg::FC_READ_COILS) ? 64'(coil_ff) : 64'(din_ff);
   assign bitbyte = 8'(src64 >> bitoff) & bmask;
   assign m64     = 64'(bmask) << bitoff;
   assign d64     = 64'(fbyte) << bitoff;

   // Response layout.
   assign hrd_addr = start_f[RA-1:0] + RA'(tmp_idx >> 1);
   assign hword    = hvq_ff ? hrd_data : mrse_pkg::HOLD_RESET;

   always_comb begin
      unique case (mode_ff)
         MODE_EXC:  body = KW'(3);
         MODE_ECHO: body = KW'(6);
         MODE_BITS: body = KW'(3) + KW'(nbytes8);
         MODE_REGS: body = KW'(3) + (KW'(cnt_f) << 1);
      endcase
      total = (mode_ff == MODE_EXC) ? body : KW'(body + KW'(2));
   end

   // Byte at the current response position.
   always_comb begin
      priority if (idx_ff >= body) begin
         tx_byte_w = (idx_ff == body) ? tx_crc_ff[7:0] : tx_crc_ff[15:8];
      end else if (idx_ff == KW'(0)) begin
         tx_byte_w = fb_ff[0];
      end else if (idx_ff == KW'(1)) begin
         tx_byte_w = (mode_ff == MODE_EXC) ? (fb_ff[1] | mrse_pkg::EXC_FLAG) : fb_ff[1];
      end else begin
         unique case (mode_ff)
            MODE_EXC:  tx_byte_w = code_ff;
            MODE_ECHO: tx_byte_w = fb_ff[idx_ff[2:0]];
            MODE_BITS: tx_byte_w = (idx_ff == KW'(2)) ? nbytes8 : bitbyte;
            MODE_REGS: tx_byte_w = (idx_ff == KW'(2)) ? {cnt_f[6:0], 1'b0}
                                   : (tmp_idx[0] ? hword[7:0] : hword[15:8]);
         endcase
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      len_in        = len_ff;
      n_in          = n_ff;
      fb_in         = fb_ff;
      last1_in      = last1_ff;
      last2_in      = last2_ff;
      crc_in        = crc_ff;
      din_in        = din_ff;
      coil_in       = coil_ff;
      exc_cnt_in    = exc_cnt_ff;
      hold_valid_in = hold_valid_ff;
      code_in       = code_ff;
      idx_in        = idx_ff;
      hi_in         = hi_ff;
      tx_crc_in     = tx_crc_ff;
      rd_zero_in    = rd_zero_ff;
      hvq_in        = hvq_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      fw_en         = 1'b0;
      hw_en         = 1'b0;
      hw_addr       = start_f[RA-1:0];
      hw_data       = {fb_ff[4], fb_ff[5]};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // Store the byte, keep the header bytes and run the CRC two bytes behind.
               fw_en = len_ff < LW'(FRAME_BYTES);
               if (len_ff == '0) begin
                  fb_in[0] = req_rx_byte;
                  for (int j = 1; j < 6; j++) begin
                     fb_in[j] = 8'h00;
                  end
                  crc_in = mrse_pkg::CRC_INIT;
               end else begin
                  if (len_ff < LW'(6)) begin
                     fb_in[len_ff[2:0]] = req_rx_byte;
                  end
                  if (len_ff >= LW'(2) && len_ff < LW'(FRAME_BYTES)) begin
                     crc_in = mrse_pkg::crc_update(crc_ff, last2_ff);
                  end
               end
               last2_in = last1_ff;
               last1_in = req_rx_byte;
               if (req_frame_end) begin
                  len_in = '0;
                  n_in   = n_next;
                  din_in = req_discrete_inputs;
                  if (n_next >= LW'(4) && n_next <= LW'(FRAME_BYTES)) begin
                     state_in = S_DECODE;
                  end
               end else begin
                  len_in = n_next;
               end
            end
         end

         S_DECODE: begin
            idx_in    = '0;
            tx_crc_in = mrse_pkg::CRC_INIT;
            state_in  = S_E_ADDR;
            if (dec_exc) begin
               exc_cnt_in = exc_cnt_ff + 16'd1;
               mode_in    = MODE_EXC;
               code_in    = dec_code;
            end else begin
               mode_in = MODE_ECHO;
               unique case (fb_ff[1])
                  mrse_pkg::FC_READ_COILS, mrse_pkg::FC_READ_INPUTS: mode_in = MODE_BITS;
                  mrse_pkg::FC_READ_REGS: mode_in = MODE_REGS;
                  mrse_pkg::FC_WRITE_COIL: begin
                     coil_in = COIL_COUNT'((64'(coil_ff) & ~(64'd1 << start_f[6:0]))
                                           | (64'(coil_on) << start_f[6:0]));
                  end
                  mrse_pkg::FC_WRITE_REG: begin
                     hw_en = 1'b1;
                     hold_valid_in[hw_addr] = 1'b1;
                  end
                  mrse_pkg::FC_WRITE_COILS: begin
                     if (cnt_f != 16'd0) begin
                        state_in = S_WC_READ;
                     end
                  end
                  mrse_pkg::FC_WRITE_REGS: begin
                     if (cnt_f != 16'd0) begin
                        state_in = S_WR_HI;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Multiple coil write: one data byte per pass.
         S_WC_READ: begin
            rd_zero_in = pos_w >= 9'(n_ff);
            state_in   = S_WC_APPLY;
         end

         S_WC_APPLY: begin
            coil_in = COIL_COUNT'((64'(coil_ff) & ~m64) | (d64 & m64));
            if (8'(idx_ff + 1'b1) == nbytes8) begin
               idx_in   = '0;
               state_in = S_E_ADDR;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_WC_READ;
            end
         end

         // Multiple register write: high byte, low byte, then the write.
         S_WR_HI: begin
            rd_zero_in = pos_w >= 9'(n_ff);
            state_in   = S_WR_LO;
         end

         S_WR_LO: begin
            hi_in      = fbyte;
            rd_zero_in = pos_w >= 9'(n_ff);
            state_in   = S_WR_WRITE;
         end

         S_WR_WRITE: begin
            hw_en   = 1'b1;
            hw_addr = start_f[RA-1:0] + RA'(idx_ff);
            hw_data = {hi_ff, fbyte};
            hold_valid_in[hw_addr] = 1'b1;
            if (16'(idx_ff + 1'b1) == cnt_f) begin
               idx_in   = '0;
               state_in = S_E_ADDR;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_WR_HI;
            end
         end

         // Response: read the holding word, build the byte, hand it over.
         S_E_ADDR: begin
            hvq_in   = (32'(hrd_addr) < REG_COUNT) ? hold_valid_ff[hrd_addr] : 1'b0;
            state_in = S_E_BYTE;
         end

         S_E_BYTE: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = tx_byte_w;
            rsp_last_in  = idx_ff == KW'(total - 1'b1);
            if (idx_ff < body) begin
               tx_crc_in = mrse_pkg::crc_update(tx_crc_ff, tx_byte_w);
            end
            state_in = S_E_WAIT;
         end

         S_E_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_E_ADDR;
               end
            end
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         coil_ff       <= '0;
         exc_cnt_ff    <= '0;
         hold_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         coil_ff       <= coil_in;
         exc_cnt_ff    <= exc_cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      n_ff        <= n_in;
      fb_ff       <= fb_in;
      last1_ff    <= last1_in;
      last2_ff    <= last2_in;
      crc_ff      <= crc_in;
      din_ff      <= din_in;
      code_ff     <= code_in;
      idx_ff      <= idx_in;
      hi_ff       <= hi_in;
      tx_crc_ff   <= tx_crc_in;
      rd_zero_ff  <= rd_zero_in;
      hvq_ff      <= hvq_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready           = state_ff == S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tx_byte         = rsp_byte_ff;
   assign rsp_tx_last         = rsp_last_ff;
   assign rsp_coil_levels     = 32'(coil_ff);
   assign rsp_exception_total = exc_cnt_ff;

endmodule

[hw/rtl/mrse_checker.sv]
// Port-level checks for the Modbus RTU slave engine, bound to the top level.
// Depends on modbus_rtu_slave_engine_core's port names.
`timescale 1ns / 1ps

module mrse_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_tx_last,
   input logic [31:0] rsp_coil_levels,
   input logic [15:0] rsp_exception_total
);

   // No request is taken while a response byte is pending.
   a_busy_while_sending: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response byte is pending");

   // The final byte ends the response.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_tx_last |=> !rsp_valid)
      else $error("response continues after its last byte");

   // The exception count only steps by one.
   a_exc_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_exception_total != $past(rsp_exception_total)
      |-> rsp_exception_total == $past(rsp_exception_total) + 16'd1)
      else $error("exception count jumped");

   // Coils change only while a frame is being handled.
   a_coil_busy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_coil_levels != $past(rsp_coil_levels) |-> !$past(req_ready))
      else $error("coils changed while idle");

   // A stalled response byte holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_tx_last))
      else $error("stalled response byte changed");

endmodule

bind modbus_rtu_slave_engine_core mrse_assertions u_mrse_assertions (.*);

[sim/mrse_checker.sv]
// Checker for the Modbus RTU slave engine: frame CRC helper, response predictor and comparison.
// Depends on mrse_pkg; instantiated by tb beside the engine core.
`timescale 1ns / 1ps

package mrse_tb_util;
   import mrse_pkg::*;

   typedef logic [7:0] octets_t[$];

   // CRC-16/MODBUS over the first n bytes of a byte list, reflected polynomial.
   function automatic logic [15:0] frame_crc(input octets_t data, input int n);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < n; i++) begin
         c ^= {8'h00, data[i]};
         repeat (8) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
         end
      end
      return c;
   endfunction
endpackage

module mrse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   input  logic [7:0]  req_discrete_inputs,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_tx_last,
   input  logic [31:0] rsp_coil_levels,
   input  logic [15:0] rsp_exception_total,
   output int          fault_count,
   output int          pending
);
   import mrse_pkg::*;
   import mrse_tb_util::*;

   localparam int COILS = 32;
   localparam int INPUTS = 8;
   localparam int REGS = 16;
   localparam int STORE_BYTES = 64;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [31:0] coils;
      logic [15:0] exc_total;
   } reply_t;

   // Mirror of the slave's state.
   logic [7:0]  rx_frame [STORE_BYTES];
   int          rx_len;
   logic [63:0] coil_bits;
   logic [15:0] hold_regs [REGS];
   logic [15:0] exc_total;
   octets_t     reply_bytes;
   reply_t      awaited_replies[$];

   function automatic logic [7:0] frame_at(input int pos);
      return (pos < rx_len && pos < STORE_BYTES) ? rx_frame[pos] : 8'h00;
   endfunction

   function automatic void append_crc();
      logic [15:0] c;
      c = frame_crc(reply_bytes, reply_bytes.size());
      reply_bytes.push_back(c[7:0]);
      reply_bytes.push_back(c[15:8]);
   endfunction

   function automatic void raise_exception(input logic [7:0] code);
      reply_bytes = {frame_at(0), frame_at(1) | EXC_FLAG, code};
      exc_total++;
   endfunction

   // Normal reply for writes: the first six request bytes plus CRC.
   function automatic void echo_header();
      reply_bytes = {};
      for (int i = 0; i < 6; i++) reply_bytes.push_back(frame_at(i));
      append_crc();
   endfunction

   function automatic bit fits(input int start, input int count, input int size);
      return (start + count - 1) < size;
   endfunction

   function automatic void read_bits(input int start, input int count, input bit coils,
                                     input logic [7:0] din);
      int nbytes;
      bit v;
      int a;
      nbytes = (count + 7) / 8;
      reply_bytes = {frame_at(0), frame_at(1), 8'(nbytes)};
      for (int i = 0; i < nbytes; i++) reply_bytes.push_back(8'h00);
      for (int i = 0; i < count; i++) begin
         a = start + i;
         if (coils) v = (a < 64) ? coil_bits[a] : 1'b0;
         else v = (a < 8) ? din[a] : 1'b0;
         if (v) reply_bytes[3 + i / 8] |= 8'(1 << (i % 8));
      end
      append_crc();
   endfunction

   // Decode a closed frame and build its reply, updating the mirrored state.
   function automatic void serve_frame(input logic [7:0] din);
      logic [7:0]  fc;
      logic [15:0] c;
      logic [7:0]  data_byte;
      octets_t     body;
      int          start, count, n;
      fc = frame_at(1);
      start = {frame_at(2), frame_at(3)};
      count = {frame_at(4), frame_at(5)};
      n = rx_len;
      if (!(fc inside {FC_READ_COILS, FC_READ_INPUTS, FC_READ_REGS, FC_WRITE_COIL,
                       FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS})) begin
         raise_exception(EXC_ILLEGAL_FUNCTION);
         return;
      end
      if (start >= ADDR_LIMIT) begin
         raise_exception(EXC_ILLEGAL_ADDRESS);
         return;
      end
      body = {};
      for (int i = 0; i < n - 2; i++) body.push_back(rx_frame[i]);
      c = frame_crc(body, n - 2);
      if (frame_at(n - 2) != c[7:0] || frame_at(n - 1) != c[15:8]) begin
         raise_exception(EXC_DEVICE_FAILURE);
         return;
      end
      case (fc)
         FC_READ_COILS, FC_READ_INPUTS: begin
            if (!fits(start, count, (fc == FC_READ_COILS) ? COILS : INPUTS))
               raise_exception(EXC_ILLEGAL_ADDRESS);
            else read_bits(start, count, fc == FC_READ_COILS, din);
         end
         FC_READ_REGS: begin
            if (!fits(start, count, REGS)) raise_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               reply_bytes = {frame_at(0), frame_at(1), 8'(count * 2)};
               for (int i = 0; i < count && start + i < REGS; i++) begin
                  reply_bytes.push_back(hold_regs[start + i][15:8]);
                  reply_bytes.push_back(hold_regs[start + i][7:0]);
               end
               append_crc();
            end
         end
         FC_WRITE_COIL: begin
            if (start >= COILS) raise_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               coil_bits[start] = (frame_at(4) == COIL_ON || frame_at(5) == COIL_ON);
               echo_header();
            end
         end
         FC_WRITE_REG: begin
            if (start >= REGS) raise_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               hold_regs[start] = {frame_at(4), frame_at(5)};
               echo_header();
            end
         end
         FC_WRITE_COILS: begin
            if (!fits(start, count, COILS)) raise_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               // The byte-count field is skipped; data bits start at byte 7.
               for (int i = 0; i < count && start + i < 64; i++) begin
                  data_byte = frame_at(7 + i / 8);
                  coil_bits[start + i] = data_byte[i % 8];
               end
               echo_header();
            end
         end
         default: begin
            if (!fits(start, count, REGS)) raise_exception(EXC_ILLEGAL_ADDRESS);
            else begin
               for (int i = 0; i < count && start + i < REGS; i++)
                  hold_regs[start + i] = {frame_at(7 + 2 * i), frame_at(8 + 2 * i)};
               echo_header();
            end
         end
      endcase
   endfunction

   // Store one request byte; at frame end, queue every reply byte it causes.
   function automatic void take_request(input logic [7:0] b, input logic end_mark,
                                        input logic [7:0] din);
      reply_t r;
      if (rx_len < STORE_BYTES) begin
         rx_frame[rx_len] = b;
         rx_len++;
      end else rx_len = STORE_BYTES + 1;
      if (!end_mark) return;
      reply_bytes = {};
      if (rx_len >= 4 && rx_len <= STORE_BYTES) serve_frame(din);
      rx_len = 0;
      foreach (reply_bytes[k]) begin
         r.tx_byte = reply_bytes[k];
         r.tx_last = (k == reply_bytes.size() - 1);
         r.coils = coil_bits[31:0];
         r.exc_total = exc_total;
         awaited_replies.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t checker: %s got %h expected %h", $time, what, got, want);
      fault_count++;
   endtask

   function automatic void clear_model();
      rx_len = 0;
      coil_bits = '0;
      foreach (hold_regs[i]) hold_regs[i] = HOLD_RESET;
      exc_total = '0;
      awaited_replies.delete();
   endfunction

   initial begin
      fault_count = 0;
      clear_model();
   end

   // Compare any reply first, then absorb any request of the same edge.
   always @(posedge clock) begin
      reply_t want;
      if (reset) clear_model();
      else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0)
               report_mismatch("unexpected reply byte", rsp_tx_byte, 0);
            else begin
               want = awaited_replies.pop_front();
               if (rsp_tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", rsp_tx_byte, want.tx_byte);
               if (rsp_tx_last !== want.tx_last)
                  report_mismatch("tx_last", rsp_tx_last, want.tx_last);
               if (rsp_coil_levels !== want.coils)
                  report_mismatch("coil_levels", rsp_coil_levels, want.coils);
               if (rsp_exception_total !== want.exc_total)
                  report_mismatch("exception_total", rsp_exception_total, want.exc_total);
            end
         end
         if (req_valid && req_ready)
            take_request(req_rx_byte, req_frame_end, req_discrete_inputs);
      end
      pending = awaited_replies.size();
   end
endmodule

[sim/tb.sv]
// Testbench top for the Modbus RTU slave engine: clock, reset, request frames, reply pacing.
// Depends on mrse_pkg, mrse_checker.sv and the engine core RTL.
`timescale 1ns / 1ps

module tb;
   import mrse_pkg::*;
   import mrse_tb_util::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_OFF = 300;
   localparam int CRC_NONE = 0;
   localparam int CRC_GOOD = 1;
   localparam int CRC_BAD = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        req_frame_end = 1'b0;
   logic [7:0]  req_discrete_inputs = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic [31:0] rsp_coil_levels;
   logic [15:0] rsp_exception_total;
   int          fault_count;
   int          pending;
   int          octets_sent = 0;
   int          frames_sent = 0;
   int          replies_seen = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;

   always #2 clock = ~clock;

   modbus_rtu_slave_engine_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .req_frame_end(req_frame_end), .req_discrete_inputs(req_discrete_inputs),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last), .rsp_coil_levels(rsp_coil_levels),
      .rsp_exception_total(rsp_exception_total)
   );

   mrse_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .req_frame_end(req_frame_end), .req_discrete_inputs(req_discrete_inputs),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last), .rsp_coil_levels(rsp_coil_levels),
      .rsp_exception_total(rsp_exception_total),
      .fault_count(fault_count), .pending(pending)
   );

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp_valid && rsp_ready) replies_seen <= replies_seen + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: watchdog expired with %0d replies pending", pending);
         $display("tb: done, errors");
         $finish;
      end
   end

   // Receiver pacing: a randomly picked mode for each stretch, plus one long hold-off.
   initial begin
      int mode;
      bit held;
      held = 0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && replies_seen >= 40) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         mode = $urandom_range(0, 2);
         for (int i = 0; i < 32; i++) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // Offer one request byte and hold it until accepted; bursts separated by gaps.
   task automatic send_octet(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_end <= last;
      req_discrete_inputs <= 8'($urandom_range(0, 255));
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
      octets_sent++;
   endtask

   task automatic send_frame(input octets_t body, input int crc_mode);
      logic [15:0] c;
      if (crc_mode != CRC_NONE) begin
         c = frame_crc(body, body.size());
         if (crc_mode == CRC_BAD) c ^= 16'(1 << $urandom_range(0, 15));
         body.push_back(c[7:0]);
         body.push_back(c[15:8]);
      end
      foreach (body[i]) send_octet(body[i], i == body.size() - 1);
      frames_sent++;
   endtask

   // Request body without CRC; write-multiple requests get random payload data.
   function automatic octets_t build_request(input logic [7:0] fc, input logic [15:0] start,
                                             input logic [15:0] count);
      octets_t body;
      int data_len;
      body = {8'($urandom_range(0, 255)), fc, start[15:8], start[7:0],
              count[15:8], count[7:0]};
      if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
         data_len = (fc == FC_WRITE_COILS) ? (count + 7) / 8 : 2 * count;
         if (data_len > 40) data_len = 40;
         body.push_back(8'(data_len));
         for (int i = 0; i < data_len; i++) body.push_back(8'($urandom_range(0, 255)));
      end
      return body;
   endfunction

   function automatic octets_t noise(input int len);
      octets_t body;
      for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
      return body;
   endfunction

   initial begin
      octets_t long_frame;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every function, extremes of range, each exception and drop case.
      send_frame(build_request(FC_READ_COILS, 16'd0, 16'd32), CRC_GOOD);
      send_frame(build_request(FC_WRITE_COIL, 16'd3, 16'hFF00), CRC_GOOD);
      send_frame(build_request(FC_WRITE_COIL, 16'd31, 16'h00FF), CRC_GOOD);
      send_frame(build_request(FC_WRITE_COIL, 16'd3, 16'h1234), CRC_GOOD);
      send_frame(build_request(FC_WRITE_COILS, 16'd0, 16'd32), CRC_GOOD);
      send_frame(build_request(FC_READ_COILS, 16'd0, 16'd32), CRC_GOOD);
      send_frame(build_request(FC_READ_INPUTS, 16'd0, 16'd8), CRC_GOOD);
      send_frame(build_request(FC_WRITE_REG, 16'd15, 16'h0000), CRC_GOOD);
      send_frame(build_request(FC_WRITE_REGS, 16'd0, 16'd4), CRC_GOOD);
      send_frame(build_request(FC_READ_REGS, 16'd0, 16'd16), CRC_GOOD);
      send_frame(build_request(FC_READ_REGS, 16'd16, 16'd0), CRC_GOOD);
      send_frame(build_request(8'h07, 16'd0, 16'd1), CRC_GOOD);
      send_frame(build_request(FC_READ_REGS, ADDR_LIMIT, 16'd1), CRC_GOOD);
      send_frame(build_request(FC_READ_REGS, 16'd0, 16'd2), CRC_BAD);
      send_frame(build_request(FC_WRITE_COIL, 16'd32, 16'hFF00), CRC_GOOD);
      send_frame(noise(3), CRC_NONE);
      long_frame = build_request(FC_READ_REGS, 16'd0, 16'd1);
      while (long_frame.size() < 63) long_frame.push_back(8'($urandom_range(0, 255)));
      send_frame(long_frame, CRC_GOOD);

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("tb: %0d frames (%0d bytes) sent, %0d reply bytes checked",
               frames_sent, octets_sent, replies_seen);
      if (fault_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule
